// ===== rtl/crm_pkg.sv =====
`timescale 1ns / 1ps

package crm_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFastWait = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSlowWait = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFastLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlowLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNotifyEn = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [TimerW-1:0] FastWaitRst = 16'd100;
  localparam logic [TimerW-1:0] SlowWaitRst = 16'd1000;
  localparam logic [CountW-1:0] FastLimitRst = 8'd5;
  localparam logic [CountW-1:0] SlowLimitRst = 8'd255;
  localparam logic NotifyEnRst = 1'b1;

  typedef struct packed {
    logic [TimerW-1:0] fast_wait_ticks;
    logic [TimerW-1:0] slow_wait_ticks;
    logic [CountW-1:0] fast_try_limit;
    logic [CountW-1:0] slow_try_limit;
    logic extended_notify_enable;
  } cfg_t;

  typedef struct packed {
    logic [TimerW-1:0] wait_timer;
    logic [CountW-1:0] attempt_count;
    logic slow_phase;
    logic error_pending;
    logic restoring;
  } state_t;

  // Packed so that the last field sits in the lowest bit.
  typedef struct packed {
    logic nm_initialized;
    logic tx_confirmed;
    logic bus_off_seen;
  } tick_t;

  typedef struct packed {
    logic [CountW-1:0] try_count;
    logic in_slow_phase;
    logic send_nm_frame;
    logic restart_com;
    logic go_online;
    logic recovery_succeeded;
    logic recovery_failed;
    logic bus_off_notice;
    logic go_offline;
  } result_t;

endpackage

// ===== rtl/crm_cfg.sv =====
`timescale 1ns / 1ps

module crm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [crm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output crm_pkg::cfg_t                 cfg_o
);

  crm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        crm_pkg::RegFastWait:  cfg_d.fast_wait_ticks = cfg_wdata_i;
        crm_pkg::RegSlowWait:  cfg_d.slow_wait_ticks = cfg_wdata_i;
        crm_pkg::RegFastLimit: cfg_d.fast_try_limit = cfg_wdata_i[crm_pkg::CountW-1:0];
        crm_pkg::RegSlowLimit: cfg_d.slow_try_limit = cfg_wdata_i[crm_pkg::CountW-1:0];
        crm_pkg::RegNotifyEn:  cfg_d.extended_notify_enable = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_wait_ticks <= crm_pkg::FastWaitRst;
      cfg_q.slow_wait_ticks <= crm_pkg::SlowWaitRst;
      cfg_q.fast_try_limit <= crm_pkg::FastLimitRst;
      cfg_q.slow_try_limit <= crm_pkg::SlowLimitRst;
      cfg_q.extended_notify_enable <= crm_pkg::NotifyEnRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/crm_step.sv =====
`timescale 1ns / 1ps

module crm_step (
  input  crm_pkg::cfg_t    cfg_i,
  input  crm_pkg::state_t  state_i,
  input  crm_pkg::tick_t   tick_i,
  output crm_pkg::state_t  state_o,
  output crm_pkg::result_t result_o
);

  logic [crm_pkg::CountW-1:0] next_count;

  always_comb begin
    state_o = state_i;
    result_o = '0;
    next_count = '0;

    // A confirm while restoring ends recovery.
    if (tick_i.tx_confirmed && state_i.restoring) begin
      state_o.attempt_count = '0;
      state_o.slow_phase = 1'b0;
      state_o.restoring = 1'b0;
      result_o.recovery_succeeded = cfg_i.extended_notify_enable;
    end

    // The timer expires on the tick that takes it from one to zero.
    if (state_i.wait_timer != '0) begin
      state_o.wait_timer = state_i.wait_timer - 1'b1;
      if (state_i.wait_timer == crm_pkg::TimerW'(1) && tick_i.nm_initialized) begin
        if (state_i.error_pending) begin
          state_o.error_pending = 1'b0;
          result_o.go_online = 1'b1;
          result_o.restart_com = cfg_i.extended_notify_enable;
        end
        result_o.send_nm_frame = 1'b1;
      end
    end

    if (tick_i.bus_off_seen) begin
      result_o.go_offline = 1'b1;
      state_o.error_pending = 1'b1;
      state_o.restoring = 1'b1;
      next_count = state_o.attempt_count + 1'b1;
      state_o.attempt_count = next_count;
      if (next_count <= cfg_i.fast_try_limit && !state_o.slow_phase) begin
        if (next_count == cfg_i.fast_try_limit) begin
          state_o.slow_phase = 1'b1;
          state_o.attempt_count = '0;
        end
        state_o.wait_timer = cfg_i.fast_wait_ticks;
        result_o.bus_off_notice = 1'b1;
      end else if (next_count <= cfg_i.slow_try_limit) begin
        state_o.wait_timer = cfg_i.slow_wait_ticks;
        result_o.bus_off_notice = 1'b1;
      end else begin
        state_o.attempt_count = '0;
        state_o.slow_phase = 1'b0;
        result_o.recovery_failed = 1'b1;
      end
    end

    result_o.in_slow_phase = state_o.slow_phase;
    result_o.try_count = state_o.attempt_count;
  end

endmodule

// ===== rtl/can_bus_off_recovery_manager_core.sv =====
`timescale 1ns / 1ps
// Channel    | Direction | Transaction
// s_axis     | in        | one main-function tick: bus-off, confirm and NM flags
// m_axis     | out       | one result per tick: action flags, phase and try count
// cfg        | in        | register write, taken whenever cfg_we_i is high
//
// Each tick is registered, evaluated against the recovery state combinationally
// and lands in the result register: one tick per cycle while m_axis is not stalled.
// The state advances when a tick moves from the input to the result register.
// rst_ni clears the recovery state and loads the register defaults.
// A stalled m_axis holds the result; the input register still takes one tick.

module can_bus_off_recovery_manager_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // bit 0 bus_off_seen, bit 1 tx_confirmed, bit 2 nm_initialized, bits 7:3 zero
  input  logic [7:0]                    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bit 0 go_offline, 1 bus_off_notice, 2 recovery_failed, 3 recovery_succeeded,
  // 4 go_online, 5 restart_com, 6 send_nm_frame, 7 in_slow_phase, 15:8 try_count
  output logic [15:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [crm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [crm_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  crm_pkg::cfg_t    cfg;
  crm_pkg::state_t  state_q, state_d;
  crm_pkg::tick_t   tick_q;
  crm_pkg::result_t res_q, res_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;

  crm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  crm_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .tick_i   (tick_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q <= s_axis_tdata[2:0];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = res_q;

`ifndef SYNTHESIS
  // Online is only ever announced together with the NM frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.go_online |-> res_q.send_nm_frame)
    else $error("go_online without send_nm_frame");

  // Failure resets the counters to the start of the fast phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.recovery_failed |->
      res_q.try_count == '0 && !res_q.in_slow_phase && !res_q.bus_off_notice)
    else $error("recovery_failed with counters not cleared");

  // The state register follows the result that was just produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> state_q.attempt_count == res_q.try_count &&
      state_q.slow_phase == res_q.in_slow_phase)
    else $error("result does not match recovery state");

  // A result held under back-pressure does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(res_q))
    else $error("stalled result changed");
`endif

endmodule
